// File: design/aiop_pkg.sv
// ----------------------------------------------------------------------------
// aiop_pkg
// Shared types, type codes, record kinds and per-type size helpers for the
// ASDU information object parser.
// ----------------------------------------------------------------------------
package aiop_pkg;

    // monitoring type identifiers
    localparam logic [7:0] TYPE_M_SP_NA = 8'd1;
    localparam logic [7:0] TYPE_M_DP_NA = 8'd3;
    localparam logic [7:0] TYPE_M_ME_NA = 8'd9;
    localparam logic [7:0] TYPE_M_ME_NB = 8'd11;
    localparam logic [7:0] TYPE_M_ME_NC = 8'd13;
    localparam logic [7:0] TYPE_M_IT_NA = 8'd15;
    localparam logic [7:0] TYPE_M_SP_TB = 8'd30;
    localparam logic [7:0] TYPE_M_DP_TB = 8'd31;
    localparam logic [7:0] TYPE_M_ME_TD = 8'd34;
    localparam logic [7:0] TYPE_M_ME_TE = 8'd35;
    localparam logic [7:0] TYPE_M_ME_TF = 8'd36;
    localparam logic [7:0] TYPE_M_IT_TB = 8'd37;

    // record kinds
    localparam logic [2:0] KIND_SINGLE = 3'd0;
    localparam logic [2:0] KIND_DOUBLE = 3'd1;
    localparam logic [2:0] KIND_NORM   = 3'd2;
    localparam logic [2:0] KIND_SCALED = 3'd3;
    localparam logic [2:0] KIND_FLOAT  = 3'd4;
    localparam logic [2:0] KIND_ITOTAL = 3'd5;
    localparam logic [2:0] KIND_NONE   = 3'd7;

    // header layout
    localparam logic [7:0] POS_TYPE    = 8'd0;
    localparam logic [7:0] POS_VSQ     = 8'd1;
    localparam logic [7:0] POS_CA_LO   = 8'd4;
    localparam logic [7:0] POS_CA_HI   = 8'd5;
    localparam logic [7:0] POS_SEQ_IOA = 8'd6;
    localparam logic [7:0] POS_MAX     = 8'd255;
    localparam logic [7:0] HDR_BYTES   = 8'd6;
    localparam logic [3:0] IOA_BYTES   = 4'd3;
    localparam logic [3:0] TIME_TAG    = 4'd7;

    // field masks
    localparam logic [7:0]  VSQ_COUNT_MASK = 8'h7f;
    localparam logic [7:0]  VSQ_SQ_MASK    = 8'h80;
    localparam logic [31:0] SP_VALUE_MASK  = 32'h01;
    localparam logic [31:0] DP_VALUE_MASK  = 32'h03;
    localparam logic [7:0]  PT_QUAL_MASK   = 8'hf0;

    typedef struct packed {
        logic [7:0] asdu_length;
        logic       first_byte;
        logic [7:0] data_byte;
    } item_t;

    function automatic logic [2:0] type_kind(input logic [7:0] t);
        logic [2:0] k;
        case (t)
            TYPE_M_SP_NA, TYPE_M_SP_TB: k = KIND_SINGLE;
            TYPE_M_DP_NA, TYPE_M_DP_TB: k = KIND_DOUBLE;
            TYPE_M_ME_NA, TYPE_M_ME_TD: k = KIND_NORM;
            TYPE_M_ME_NB, TYPE_M_ME_TE: k = KIND_SCALED;
            TYPE_M_ME_NC, TYPE_M_ME_TF: k = KIND_FLOAT;
            TYPE_M_IT_NA, TYPE_M_IT_TB: k = KIND_ITOTAL;
            default:                    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic has_time_tag(input logic [7:0] t);
        return (t == TYPE_M_SP_TB) || (t == TYPE_M_DP_TB) || (t == TYPE_M_ME_TD) ||
               (t == TYPE_M_ME_TE) || (t == TYPE_M_ME_TF) || (t == TYPE_M_IT_TB);
    endfunction

    // object data bytes without the address, zero for unsupported types
    function automatic logic [3:0] data_len(input logic [7:0] t);
        logic [3:0] base;
        case (type_kind(t))
            KIND_SINGLE, KIND_DOUBLE: base = 4'd1;
            KIND_NORM, KIND_SCALED:   base = 4'd3;
            KIND_FLOAT, KIND_ITOTAL:  base = 4'd5;
            default:                  base = 4'd0;
        endcase
        if (base != 4'd0 && has_time_tag(t)) begin
            base = base + TIME_TAG;
        end
        return base;
    endfunction

    // offset of the quality byte within the object data
    function automatic logic [3:0] quality_index(input logic [2:0] k);
        logic [3:0] q;
        case (k)
            KIND_SINGLE, KIND_DOUBLE: q = 4'd0;
            KIND_NORM, KIND_SCALED:   q = 4'd2;
            default:                  q = 4'd4;
        endcase
        return q;
    endfunction

endpackage

// File: design/aiop_in_stage.sv
// ----------------------------------------------------------------------------
// aiop_in_stage
// Input register: holds one byte transfer until the parse stage takes it.
// ----------------------------------------------------------------------------
module aiop_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  aiop_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output aiop_pkg::item_t item
);
    import aiop_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    assign s_tready   = !vld_reg || take;
    assign vld_next   = s_tready ? s_tvalid : vld_reg;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

endmodule

// File: design/aiop_parse.sv
// ----------------------------------------------------------------------------
// aiop_parse
// Header decode, acceptance check and object assembly, one byte per cycle when
// the record output register is not stalled, with the record output register.
// ----------------------------------------------------------------------------
module aiop_parse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            item_valid,
    input  aiop_pkg::item_t item,
    output logic            take,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [2:0]      rec_kind,
    output logic [15:0]     rec_ca,
    output logic [24:0]     rec_addr,
    output logic [31:0]     rec_value,
    output logic [7:0]      rec_quality
);
    import aiop_pkg::*;

    logic [7:0]  pos_reg,    pos_next;
    logic [7:0]  type_reg,   type_next;
    logic [6:0]  count_reg,  count_next;
    logic        seq_reg,    seq_next;
    logic        acc_reg,    acc_next;
    logic [15:0] ca_reg,     ca_next;
    logic [24:0] addr_reg,   addr_next;
    logic [3:0]  bio_reg,    bio_next;
    logic [6:0]  done_reg,   done_next;
    logic [31:0] va_reg,     va_next;
    logic [7:0]  q_reg,      q_next;
    logic        ovld_reg,   ovld_next;
    logic [2:0]  okind_reg;
    logic [24:0] oaddr_reg;
    logic [31:0] oval_reg;
    logic [7:0]  oq_reg;

    logic        proc;
    logic        emit;
    logic [7:0]  pos;
    logic [7:0]  val;
    logic [2:0]  kind;
    logic [3:0]  dsz;
    logic [3:0]  hdr;
    logic [4:0]  total;
    logic [3:0]  d;
    logic [10:0] need;
    logic [10:0] room;
    logic [31:0] out_val;
    logic [7:0]  out_q;

    assign take  = !ovld_reg || m_tready;
    assign proc  = item_valid && take;
    assign val   = item.data_byte;
    assign pos   = item.first_byte ? POS_TYPE : pos_reg;
    assign kind  = type_kind(type_reg);
    assign dsz   = data_len(type_reg);
    assign hdr   = seq_reg ? 4'd0 : IOA_BYTES;
    assign total = {1'b0, hdr} + {1'b0, dsz};
    assign d     = bio_reg - hdr;
    assign need  = seq_reg ? ({7'd0, IOA_BYTES} + {4'd0, count_reg} * {7'd0, dsz})
                           : ({4'd0, count_reg} * {7'd0, IOA_BYTES + dsz});
    assign room  = {3'd0, item.asdu_length - HDR_BYTES};

    always_comb begin
        pos_next   = pos_reg;
        type_next  = type_reg;
        count_next = count_reg;
        seq_next   = seq_reg;
        acc_next   = acc_reg;
        ca_next    = ca_reg;
        addr_next  = addr_reg;
        bio_next   = bio_reg;
        done_next  = done_reg;
        va_next    = va_reg;
        q_next     = q_reg;
        emit       = 1'b0;
        if (proc) begin
            pos_next = (pos != POS_MAX) ? pos + 8'd1 : pos;
            if (pos == POS_TYPE) begin
                type_next = val;
                acc_next  = 1'b0;
            end else if (pos == POS_VSQ) begin
                count_next = 7'(val & VSQ_COUNT_MASK);
                seq_next   = (val & VSQ_SQ_MASK) != 8'd0;
            end else if (pos < POS_CA_LO) begin
                // cause of transmission and originator are ignored
            end else if (pos == POS_CA_LO) begin
                ca_next = {ca_reg[15:8], val};
            end else if (pos == POS_CA_HI) begin
                ca_next   = {val, ca_reg[7:0]};
                acc_next  = (item.asdu_length >= HDR_BYTES) && (dsz != 4'd0) &&
                            (count_reg != 7'd0) && (need <= room);
                bio_next  = 4'd0;
                done_next = 7'd0;
                addr_next = 25'd0;
                va_next   = 32'd0;
                q_next    = 8'd0;
            end else if (acc_reg) begin
                if (seq_reg && pos < POS_SEQ_IOA + 8'd3) begin
                    // shared base address of a sequence
                    case (pos[1:0])
                        2'd2:    addr_next = addr_reg | {17'd0, val};
                        2'd3:    addr_next = addr_reg | {9'd0, val, 8'd0};
                        default: addr_next = addr_reg | {1'd0, val, 16'd0};
                    endcase
                end else begin
                    if (bio_reg < hdr) begin
                        case (bio_reg[1:0])
                            2'd0:    addr_next = {17'd0, val};
                            2'd1:    addr_next = addr_reg | {9'd0, val, 8'd0};
                            default: addr_next = addr_reg | {1'd0, val, 16'd0};
                        endcase
                    end else begin
                        case (d)
                            4'd0:    va_next = {24'd0, val};
                            4'd1:    va_next = va_reg | {16'd0, val, 8'd0};
                            4'd2:    va_next = va_reg | {8'd0, val, 16'd0};
                            4'd3:    va_next = va_reg | {val, 24'd0};
                            default: va_next = va_reg;
                        endcase
                        if (d == quality_index(kind)) begin
                            q_next = val;
                        end
                    end
                    if ({1'b0, bio_reg} + 5'd1 < total) begin
                        bio_next = bio_reg + 4'd1;
                    end else begin
                        bio_next  = 4'd0;
                        emit      = 1'b1;
                        done_next = done_reg + 7'd1;
                        if (done_next >= count_reg) begin
                            acc_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        case (kind)
            KIND_SINGLE: begin
                out_val = va_next & SP_VALUE_MASK;
                out_q   = q_next & PT_QUAL_MASK;
            end
            KIND_DOUBLE: begin
                out_val = va_next & DP_VALUE_MASK;
                out_q   = q_next & PT_QUAL_MASK;
            end
            KIND_NORM, KIND_SCALED: begin
                out_val = {{16{va_next[15]}}, va_next[15:0]};
                out_q   = q_next;
            end
            default: begin
                out_val = va_next;
                out_q   = q_next;
            end
        endcase
    end

    assign ovld_next = take ? emit : ovld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 8'd0;
            type_reg  <= 8'd0;
            count_reg <= 7'd0;
            seq_reg   <= 1'b0;
            acc_reg   <= 1'b0;
            ca_reg    <= 16'd0;
            addr_reg  <= 25'd0;
            bio_reg   <= 4'd0;
            done_reg  <= 7'd0;
            va_reg    <= 32'd0;
            q_reg     <= 8'd0;
            ovld_reg  <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            type_reg  <= type_next;
            count_reg <= count_next;
            seq_reg   <= seq_next;
            acc_reg   <= acc_next;
            ca_reg    <= ca_next;
            // sequence mode steps the address after each completed object
            addr_reg  <= (emit && seq_reg) ? addr_next + 25'd1 : addr_next;
            bio_reg   <= bio_next;
            done_reg  <= done_next;
            va_reg    <= va_next;
            q_reg     <= q_next;
            ovld_reg  <= ovld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            okind_reg <= kind;
            oaddr_reg <= addr_next;
            oval_reg  <= out_val;
            oq_reg    <= out_q;
        end
    end

    assign m_tvalid    = ovld_reg;
    assign rec_kind    = okind_reg;
    assign rec_ca      = ca_reg;
    assign rec_addr    = oaddr_reg;
    assign rec_value   = oval_reg;
    assign rec_quality = oq_reg;

endmodule

// File: design/asdu_information_object_parser_core.sv
// ----------------------------------------------------------------------------
// asdu_information_object_parser_core
// Streaming parser for monitoring ASDUs: one byte per transfer in, one record
// per completed information object out.
// ----------------------------------------------------------------------------
// path: the object's last byte passes the input register, then the parse step loads the record output register
// throughput: one byte per cycle while m_tready does not stall the record output register
// reset: synchronous active-low aresetn clears the header and object state
// and empties both the input and the output register
module asdu_information_object_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // data_byte[7:0], asdu_length[15:8]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // station_address[15:0], object_address[40:16],
                                   // raw_value[72:41], quality[80:73], zero[87:81]
    output logic [2:0]  m_tuser    // record_kind
);
    import aiop_pkg::*;

    item_t       s_item;
    item_t       item;
    logic        item_valid;
    logic        take;
    logic [2:0]  rec_kind;
    logic [15:0] rec_ca;
    logic [24:0] rec_addr;
    logic [31:0] rec_value;
    logic [7:0]  rec_quality;

    assign s_item.data_byte   = s_tdata[7:0];
    assign s_item.asdu_length = s_tdata[15:8];
    assign s_item.first_byte  = s_tuser;

    aiop_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    aiop_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .rec_kind    (rec_kind),
        .rec_ca      (rec_ca),
        .rec_addr    (rec_addr),
        .rec_value   (rec_value),
        .rec_quality (rec_quality)
    );

    assign m_tdata = {7'd0, rec_quality, rec_value, rec_addr, rec_ca};
    assign m_tuser = rec_kind;

endmodule
